>>> design/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

  // axis selected as the leading component: W when the trace is positive, else X, Y or Z
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_W = 2'd3
  } axis_t;

  // cyclic successor of an axis among X, Y and Z; W maps to X
  function automatic axis_t next_axis(input axis_t a);
    axis_t n;
    unique case (a)
      AXIS_X:  n = AXIS_Y;
      AXIS_Y:  n = AXIS_Z;
      default: n = AXIS_X;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

>>> design/rotation_matrix_to_quaternion.sv
`default_nettype none
// Converts one 3x3 rotation matrix per cycle into a quaternion (w,x,y,z),
// all in signed fixed point with FRAC_BITS fraction bits. A matrix is taken
// whenever start is high; busy is always low, so a new request may follow in
// every cycle. The result appears on out_* with out_valid high for exactly
// one cycle, in request order; the receiver cannot stall. SW, the root
// width, is (ELEM_BITS+FRAC_BITS+3)/2. Each matrix passes through the
// pipelined bit-per-stage square root followed by the pipelined
// bit-per-stage dividers. bad_root flags a non-positive radicand, with all
// components zero.
module rotation_matrix_to_quaternion #(
  parameter int ELEM_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [ELEM_BITS-1:0] in_r0c0,
  input  wire logic signed [ELEM_BITS-1:0] in_r0c1,
  input  wire logic signed [ELEM_BITS-1:0] in_r0c2,
  input  wire logic signed [ELEM_BITS-1:0] in_r1c0,
  input  wire logic signed [ELEM_BITS-1:0] in_r1c1,
  input  wire logic signed [ELEM_BITS-1:0] in_r1c2,
  input  wire logic signed [ELEM_BITS-1:0] in_r2c0,
  input  wire logic signed [ELEM_BITS-1:0] in_r2c1,
  input  wire logic signed [ELEM_BITS-1:0] in_r2c2,
  output logic                             out_valid,
  output logic signed [ELEM_BITS-1:0]      out_quat_w,
  output logic signed [ELEM_BITS-1:0]      out_quat_x,
  output logic signed [ELEM_BITS-1:0]      out_quat_y,
  output logic signed [ELEM_BITS-1:0]      out_quat_z,
  output logic                             out_bad_root
);
  import rmq_pkg::*;

  localparam int EW  = ELEM_BITS;
  localparam int RDW = EW + 3;                 // radicand width, signed
  localparam int SQW = RDW - 1 + FRAC_BITS;    // radicand << frac, unsigned
  localparam int SW  = (SQW + 1) / 2;          // root width
  localparam int NIT = SW;                     // root iterations
  localparam int DNW = EW + 2;                 // numerator width, signed
  localparam int MW  = DNW - 1;                // magnitude width
  localparam int NUMW = MW + FRAC_BITS;        // dividend width
  localparam int DVW = SW + 1;                 // divisor 2*s
  localparam int QW  = NUMW;                   // quotient width
  localparam int TGW = 3 * 1 + 2 + 1 + SW;     // signs, axis, bad, root

  assign busy = 1'b0;

  // ---------------- stage 1: trace, pivot, radicand, numerators
  logic signed [EW-1:0] m [3][3];
  always_comb begin
    m[0][0] = in_r0c0; m[0][1] = in_r0c1; m[0][2] = in_r0c2;
    m[1][0] = in_r1c0; m[1][1] = in_r1c1; m[1][2] = in_r1c2;
    m[2][0] = in_r2c0; m[2][1] = in_r2c1; m[2][2] = in_r2c2;
  end

  logic signed [RDW-1:0] trace_c, rad_nxt;
  logic signed [DNW-1:0] d0_nxt, d1_nxt, d2_nxt;
  axis_t                 ax_nxt;

  // pick leading component and its three partner numerators
  always_comb begin
    logic [1:0] i, j, k;
    logic signed [EW-1:0] mii, mjj, mkk;
    trace_c = RDW'(m[0][0]) + RDW'(m[1][1]) + RDW'(m[2][2]);
    i = 2'd0;
    if (m[1][1] > m[0][0]) i = 2'd1;
    if (m[2][2] > m[i][i]) i = 2'd2;
    j = next_axis(axis_t'(i));
    k = next_axis(axis_t'(j));
    mii = m[i][i]; mjj = m[j][j]; mkk = m[k][k];
    if (trace_c > 0) begin
      ax_nxt  = AXIS_W;
      rad_nxt = trace_c + RDW'(1 << FRAC_BITS);
      d0_nxt  = DNW'(m[1][2]) - DNW'(m[2][1]);
      d1_nxt  = DNW'(m[2][0]) - DNW'(m[0][2]);
      d2_nxt  = DNW'(m[0][1]) - DNW'(m[1][0]);
    end else begin
      ax_nxt  = axis_t'(i);
      rad_nxt = RDW'(mii) - RDW'(mjj) - RDW'(mkk) + RDW'(1 << FRAC_BITS);
      d0_nxt  = DNW'(m[j][k]) - DNW'(m[k][j]);
      d1_nxt  = DNW'(m[i][j]) + DNW'(m[j][i]);
      d2_nxt  = DNW'(m[i][k]) + DNW'(m[k][i]);
    end
  end

  logic                  s1_vld_r;
  logic signed [RDW-1:0] s1_rad_r;
  logic signed [DNW-1:0] s1_d_r [3];
  axis_t                 s1_ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
    s1_rad_r  <= rad_nxt;
    s1_d_r[0] <= d0_nxt;
    s1_d_r[1] <= d1_nxt;
    s1_d_r[2] <= d2_nxt;
    s1_ax_r   <= ax_nxt;
  end

  // ---------------- stage 2: magnitudes, signs, bad flag
  logic              s2_vld_r, s2_bad_r;
  logic [SQW-1:0]    s2_sq_r;
  logic [MW-1:0]     s2_mag_r [3];
  logic [2:0]        s2_neg_r;
  axis_t             s2_ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_bad_r <= (s1_rad_r <= 0);
    s2_sq_r  <= (s1_rad_r <= 0) ? '0
                : {s1_rad_r[RDW-2:0], {FRAC_BITS{1'b0}}};
    s2_ax_r  <= s1_ax_r;
    for (int n = 0; n < 3; n++) begin
      s2_neg_r[n] <= s1_d_r[n][DNW-1];
      s2_mag_r[n] <= s1_d_r[n][DNW-1] ? MW'(-s1_d_r[n]) : MW'(s1_d_r[n]);
    end
  end

  // ---------------- square root pipeline: one result bit per stage
  logic [NIT:0]       sq_vld_r;
  logic [2*SW-1:0]    sq_rem_r [NIT+1];
  logic [2*SW-1:0]    sq_num_r [NIT+1];
  logic [SW-1:0]      sq_res_r [NIT+1];
  logic [MW-1:0]      sq_mag_r [NIT+1][3];
  logic [2:0]         sq_neg_r [NIT+1];
  axis_t              sq_ax_r  [NIT+1];
  logic               sq_bad_r [NIT+1];

  always_comb begin
    sq_vld_r[0] = s2_vld_r;
    sq_rem_r[0] = '0;
    sq_num_r[0] = (2*SW)'(s2_sq_r);
    sq_res_r[0] = '0;
    sq_mag_r[0] = s2_mag_r;
    sq_neg_r[0] = s2_neg_r;
    sq_ax_r[0]  = s2_ax_r;
    sq_bad_r[0] = s2_bad_r;
  end

  for (genvar g = 0; g < NIT; g++) begin : g_sqrt
    logic [2*SW+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {sq_rem_r[g], sq_num_r[g][2*SW-1-2*g -: 2]};
      trial  = rem_sh - {SW'(0), sq_res_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[g+1] <= 1'b0;
      else        sq_vld_r[g+1] <= sq_vld_r[g];
      sq_num_r[g+1] <= sq_num_r[g];
      sq_mag_r[g+1] <= sq_mag_r[g];
      sq_neg_r[g+1] <= sq_neg_r[g];
      sq_ax_r[g+1]  <= sq_ax_r[g];
      sq_bad_r[g+1] <= sq_bad_r[g];
      if (!trial[2*SW+1]) begin
        sq_rem_r[g+1] <= trial[2*SW-1:0];
        sq_res_r[g+1] <= {sq_res_r[g][SW-2:0], 1'b1};
      end else begin
        sq_rem_r[g+1] <= rem_sh[2*SW-1:0];
        sq_res_r[g+1] <= {sq_res_r[g][SW-2:0], 1'b0};
      end
    end
  end

  // ---------------- three dividers: |D| << frac / 2s
  logic [SW-1:0]  root;
  logic [DVW-1:0] den;
  logic [TGW-1:0] tag_in;
  assign root   = sq_res_r[NIT];
  // bad radicand gives root 0; force divisor nonzero, result discarded
  assign den    = (root == '0) ? DVW'(1) : {root, 1'b0};
  assign tag_in = {sq_neg_r[NIT], sq_ax_r[NIT], sq_bad_r[NIT], root};

  logic [2:0]     dv_vld;
  logic [QW-1:0]  dv_q [3];
  logic [TGW-1:0] dv_tag [3];

  for (genvar n = 0; n < 3; n++) begin : g_div
    rmq_div #(.NW(NUMW), .DW(DVW), .QW(QW), .TW(TGW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sq_vld_r[NIT]),
      .in_num   ({sq_mag_r[NIT][n], {FRAC_BITS{1'b0}}}),
      .in_den   (den),
      .in_tag   (tag_in),
      .out_valid(dv_vld[n]),
      .out_quot (dv_q[n]),
      .out_tag  (dv_tag[n])
    );
  end

  // ---------------- final stage: sign, saturate, route
  localparam logic signed [EW:0] SMAX = (EW+1)'((1 << (EW-1)) - 1);

  function automatic logic [EW-1:0] sat_mag(input logic [QW-1:0] q, input logic neg);
    logic [EW-1:0] r;
    if (q > QW'(SMAX)) r = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    else               r = neg ? EW'(-q) : EW'(q);
    return r;
  endfunction

  logic [2:0]    t_neg;
  axis_t         t_ax;
  logic          t_bad;
  logic [SW-1:0] t_root;
  logic [EW-1:0] c0, c1, c2, lead;
  logic [EW-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;

  always_comb begin
    logic [SW-1:0] half;
    {t_neg, t_ax, t_bad, t_root} = dv_tag[0];
    c0 = sat_mag(dv_q[0], t_neg[0]);
    c1 = sat_mag(dv_q[1], t_neg[1]);
    c2 = sat_mag(dv_q[2], t_neg[2]);
    half = t_root >> 1;
    lead = (half > SW'(SMAX)) ? {1'b0, {(EW-1){1'b1}}} : EW'(half);
    unique case (t_ax)
      AXIS_W: begin qw_nxt = lead; qx_nxt = c0; qy_nxt = c1; qz_nxt = c2; end
      AXIS_X: begin qw_nxt = c0; qx_nxt = lead; qy_nxt = c1; qz_nxt = c2; end
      AXIS_Y: begin qw_nxt = c0; qy_nxt = lead; qz_nxt = c1; qx_nxt = c2; end
      default: begin qw_nxt = c0; qz_nxt = lead; qx_nxt = c1; qy_nxt = c2; end
    endcase
    if (t_bad) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end
  end

  logic          o_vld_r, o_bad_r;
  logic [EW-1:0] o_w_r, o_x_r, o_y_r, o_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else        o_vld_r <= dv_vld[0];
    o_bad_r <= t_bad;
    o_w_r   <= qw_nxt;
    o_x_r   <= qx_nxt;
    o_y_r   <= qy_nxt;
    o_z_r   <= qz_nxt;
  end

  assign out_valid    = o_vld_r;
  assign out_bad_root = o_bad_r;
  assign out_quat_w   = o_w_r;
  assign out_quat_x   = o_x_r;
  assign out_quat_y   = o_y_r;
  assign out_quat_z   = o_z_r;

`ifndef SYNTHESIS
  // the three dividers run in lockstep
  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2])
    else $error("divider lanes out of step");
  // flagged results carry zero components
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_root |-> out_quat_w == '0 && out_quat_x == '0
    && out_quat_y == '0 && out_quat_z == '0)
    else $error("bad root with nonzero output");
  // a positive trace never yields a bad radicand
  a_w_good: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_ax_r == AXIS_W |-> s1_rad_r > 0)
    else $error("trace path with non-positive radicand");
`endif

endmodule
`default_nettype wire

>>> design/rmq_div.sv
`default_nettype none
// pipelined restoring divider: one quotient bit per stage, unsigned
// quotient = floor(num / den), truncated to QW bits; tag travels alongside
module rmq_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot,
  output logic [TW-1:0]      out_tag
);

  localparam int RW = DW + 1;

  logic [NW-1:0]   vld_r;
  logic [NW-1:0]   num_r [NW+1];
  logic [DW-1:0]   den_r [NW+1];
  logic [RW-1:0]   rem_r [NW+1];
  logic [QW-1:0]   quo_r [NW+1];
  logic [TW-1:0]   tag_r [NW+1];

  // stage 0 load
  always_comb begin
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    quo_r[0] = '0;
    tag_r[0] = in_tag;
  end

  // valid bit k marks the data leaving stage k
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NW-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [RW:0]   trial_nxt;
    logic [RW:0]   shifted;
    // shift in next numerator bit, subtract if it fits
    always_comb begin
      shifted   = {rem_r[g], num_r[g][NW-1-g]};
      trial_nxt = shifted - {2'b00, den_r[g]};
    end
    always_ff @(posedge clk) begin
      num_r[g+1] <= num_r[g];
      den_r[g+1] <= den_r[g];
      tag_r[g+1] <= tag_r[g];
      if (!trial_nxt[RW]) begin
        rem_r[g+1] <= trial_nxt[RW-1:0];
        quo_r[g+1] <= {quo_r[g][QW-2:0], 1'b1};
      end else begin
        rem_r[g+1] <= shifted[RW-1:0];
        quo_r[g+1] <= {quo_r[g][QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quot  = quo_r[NW];
  assign out_tag   = tag_r[NW];

endmodule
`default_nettype wire

>>> tb/sv/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 100ps
`default_nettype none

// expected quaternions, oldest first, with mismatch bookkeeping
class quat_scoreboard;
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               bad;
  } quat_t;

  quat_t pending[$];
  int    mismatches;

  // integer square root by bit-pair search
  static function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // numerator over twice the root, truncated toward zero
  static function automatic longint frac_div(longint d, longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag << 14) / (2 * s);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  static function automatic logic signed [15:0] clamp(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // work out the quaternion of an accepted request
  function void note_request(logic signed [15:0] e[9]);
    longint m[3][3];
    longint q[4];
    longint tr;
    longint rad;
    longint unsigned s;
    int i, j, k;
    quat_t r;
    for (int a = 0; a < 9; a++) m[a / 3][a % 3] = e[a];
    tr = m[0][0] + m[1][1] + m[2][2];
    r = '0;
    if (tr > 0) begin
      s = root_of(longint'(tr + 16384) << 14);
      q[0] = s >> 1;
      q[1] = frac_div(m[1][2] - m[2][1], s);
      q[2] = frac_div(m[2][0] - m[0][2], s);
      q[3] = frac_div(m[0][1] - m[1][0], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + 16384;
      if (rad <= 0) begin
        r.bad = 1'b1;
        pending.push_back(r);
        return;
      end
      s = root_of(longint'(rad) << 14);
      q[1 + i] = s >> 1;
      q[0] = frac_div(m[j][k] - m[k][j], s);
      q[1 + j] = frac_div(m[i][j] + m[j][i], s);
      q[1 + k] = frac_div(m[i][k] + m[k][i], s);
    end
    r.w = clamp(q[0]);
    r.x = clamp(q[1]);
    r.y = clamp(q[2]);
    r.z = clamp(q[3]);
    pending.push_back(r);
  endfunction

  // compare one delivered quaternion with the oldest expectation
  function void check_result(quat_t act);
    quat_t exp_q;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", act);
      return;
    end
    exp_q = pending.pop_front();
    if (act !== exp_q) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d bad=%b, got w=%0d x=%0d y=%0d z=%0d bad=%b",
                 exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.bad,
                 act.w, act.x, act.y, act.z, act.bad);
    end
  endfunction
endclass

module rotation_matrix_to_quaternion_test;
  localparam int LATENCY = 70;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic signed [15:0] elem[9];
  logic               busy;
  logic               out_valid;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic               out_bad_root;
  quat_scoreboard     board;

  initial for (int a = 0; a < 9; a++) elem[a] = '0;

  always #6 clk = ~clk;

  rotation_matrix_to_quaternion u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r0c0(elem[0]), .in_r0c1(elem[1]), .in_r0c2(elem[2]),
    .in_r1c0(elem[3]), .in_r1c1(elem[4]), .in_r1c2(elem[5]),
    .in_r2c0(elem[6]), .in_r2c1(elem[7]), .in_r2c2(elem[8]),
    .out_valid(out_valid), .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z), .out_bad_root(out_bad_root)
  );

  // request accept and result capture at each edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_request(elem);
    if (rst_n && out_valid)
      board.check_result({out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_bad_root});
  end

  // present one request and hold it until accepted
  task automatic send_matrix(input logic signed [15:0] v[9]);
    start <= 1'b1;
    for (int a = 0; a < 9; a++) elem[a] <= v[a];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      2: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      default: return 16'($urandom());
    endcase
  endfunction

  // random matrix, half with a shaped diagonal (one lead or all positive)
  task automatic random_matrix(output logic signed [15:0] v[9]);
    int kind;
    int lead;
    kind = $urandom_range(0, 3);
    lead = $urandom_range(0, 2);
    for (int a = 0; a < 9; a++) v[a] = rand_elem();
    if (kind == 0) begin
      for (int a = 0; a < 3; a++) v[4 * a] = -$signed(16'($urandom_range(0, 16384)));
      v[4 * lead] = 16'($urandom_range(0, 16384));
    end else if (kind == 1) begin
      for (int a = 0; a < 3; a++) v[4 * a] = 16'($urandom_range(0, 16384));
    end
  endtask

  initial begin
    logic signed [15:0] v[9];
    logic signed [15:0] d[9];
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, half turns about each axis, ties, extremes, zero
    d = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    send_matrix(d);
    d = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    send_matrix(d);
    d = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    send_matrix(d);
    d = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    send_matrix(d);
    d = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(d);
    d = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192};
    send_matrix(d);
    d = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    send_matrix(d);
    d = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(d);
    d = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_matrix(d);
    d = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1};
    send_matrix(d);
    d = '{0, 32767, 32767, 32767, 0, 32767, 32767, 32767, -1};
    send_matrix(d);
    d = '{32767, -32768, 0, 32767, 0, -32768, 0, 0, 0};
    send_matrix(d);
    d = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    send_matrix(d);
    d = '{0, 11585, 0, -11585, 0, 0, 0, 0, -16384};
    send_matrix(d);
    d = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_matrix(d);

    // drain before the random part
    pause_cycles(1);
    while (board.pending.size() != 0) @(posedge clk);

    // random bursts with random gaps
    for (int n = 0; n < 1800; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 1800; b++, n++) begin
        random_matrix(v);
        send_matrix(v);
      end
      if ($urandom_range(0, 2) != 0) pause_cycles($urandom_range(1, 12));
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("** rotation_matrix_to_quaternion: PASSED **");
    else
      $display("** rotation_matrix_to_quaternion: FAILED **");
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("** rotation_matrix_to_quaternion: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
